>>> rtl/hrft_pkg.sv
package hrft_pkg;

    localparam int KCAL_BITS = 32;
    localparam int KSUM_W    = KCAL_BITS + 2;

    localparam int DIVD_W    = 23;
    localparam int DIVS_W    = 8;
    localparam int QUO_W     = DIVD_W;
    localparam int DIV_STEPS = DIVD_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam int MA_W = 28;
    localparam int MB_W = 17;
    localparam int MP_W = MA_W + MB_W;

    typedef enum logic [1:0] {
        CFG_AGE    = 2'd0,
        CFG_MALE   = 2'd1,
        CFG_WEIGHT = 2'd2
    } cfg_idx_t;

    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_INTERVAL = 1'b1;

    localparam logic [6:0]  AGE_RST    = 7'd30;
    localparam logic [7:0]  WEIGHT_RST = 8'd70;
    localparam logic [9:0]  REST_RST   = 10'd1000;
    localparam logic [2:0]  ZONE_RST   = 3'd1;

    localparam logic [11:0] HRMAX_X10  = 12'd2090;
    localparam logic [12:0] RECIP_10   = 13'd6554;

    localparam logic [15:0] PCT_60 = 16'd15360;
    localparam logic [15:0] PCT_70 = 16'd17920;
    localparam logic [15:0] PCT_80 = 16'd20480;
    localparam logic [15:0] PCT_90 = 16'd23040;

    localparam logic signed [MB_W-1:0] M_CA   = 17'sd9882;
    localparam logic signed [MB_W-1:0] M_CW16 = 17'sd49824;
    localparam logic signed [MB_W-1:0] M_CY16 = 17'sd50544;
    localparam logic signed [MA_W-1:0] M_K16  = -28'sd13808144;
    localparam logic signed [MB_W-1:0] F_CA   = 17'sd7005;
    localparam logic signed [MB_W-1:0] F_CW16 = -17'sd31648;
    localparam logic signed [MB_W-1:0] F_CY16 = 17'sd18544;
    localparam logic signed [MA_W-1:0] F_K16  = -28'sd5113104;

    localparam logic signed [MP_W-1:0] ROUND_HALF = 45'sd524288;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/hrft_div.sv
module hrft_div
    import hrft_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [DIVS_W-1:0] dsr_reg, dsr_next;
    logic [DIVS_W:0]   shifted;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        shifted   = {rem_reg, quo_reg[QUO_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = DIVS_W'(shifted - {1'b0, dsr_reg});
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIVS_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> rtl/hrft_mul.sv
module hrft_mul
    import hrft_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [MA_W-1:0] a,
    input  logic signed [MB_W-1:0] b,
    output logic signed [MP_W-1:0] prod
);

    logic signed [MP_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= MP_W'(a) * MP_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/heart_rate_fitness_tracker_unit.sv
// channel | signals                                               | dir
// in      | in_valid in_ready op heart_rate avg_heart_rate duration_min | in
// out     | out_valid out_ready max_rate rest_rate percent_of_max zone total_kcal | out
// cfg     | cfg_valid cfg_ready cfg_index cfg_data                 | in
//
// Sample items pass from accept through the bit-serial percent divider to
// commit; interval items also take six steps through the shared multiplier
// for the energy term before they reach the commit state.
// in_ready is high only while no item is in progress; a waiting result
// holds in the output register and does not block the next accept, but a
// finished item waits at commit until the output register is free.
// Async active-low reset restores the register and statistic defaults.
module heart_rate_fitness_tracker_unit
    import hrft_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [7:0]         heart_rate,
    input  logic [11:0]        avg_heart_rate,
    input  logic [15:0]        duration_min,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         max_rate,
    output logic [9:0]         rest_rate,
    output logic [15:0]        percent_of_max,
    output logic [2:0]         zone,
    output logic signed [31:0] total_kcal,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]  age_reg, age_next;
    logic        male_reg, male_next;
    logic [7:0]  weight_reg, weight_next;

    logic [7:0]  peak_reg, peak_next;
    logic [9:0]  resting_reg, resting_next;
    logic [15:0] pct_reg, pct_next;
    logic [2:0]  zone_reg, zone_next;
    logic signed [KCAL_BITS-1:0] kcal_reg, kcal_next;

    logic        op_reg, op_next;
    logic [7:0]  hr_reg, hr_next;
    logic [11:0] avg_reg, avg_next;
    logic [15:0] dur_reg, dur_next;
    logic [15:0] newpct_reg, newpct_next;
    logic signed [MA_W-1:0]      acc_reg, acc_next;
    logic signed [KCAL_BITS-1:0] knew_reg, knew_next;

    logic        ovalid_reg, ovalid_next;
    logic [7:0]  omax_reg, omax_next;
    logic [9:0]  orest_reg, orest_next;
    logic [15:0] opct_reg, opct_next;
    logic [2:0]  ozone_reg, ozone_next;
    logic signed [KCAL_BITS-1:0] okcal_reg, okcal_next;

    div_req_t    dreq;
    div_rsp_t    drsp;

    logic                   mul_en;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;

    logic [7:0]             hsel;
    logic [11:0]            hrmax_x10;
    logic [24:0]            hrmax_prod;
    logic [15:0]            quo_sat;
    logic signed [MP_W-1:0] rnd;
    logic signed [24:0]     inc;
    logic [KSUM_W-1:0]      ksum;
    logic [KSUM_W-KCAL_BITS:0] ktop;
    logic signed [63:0]     kcal_wide;

    hrft_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    hrft_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // predicted max = floor((2090 - 7*age) / 10) via reciprocal
    assign hsel       = op ? avg_heart_rate[11:4] : heart_rate;
    assign hrmax_x10  = HRMAX_X10 - 12'(7 * age_reg);
    assign hrmax_prod = 25'(hrmax_x10 * RECIP_10);

    assign dreq.start    = in_valid && in_ready;
    assign dreq.dividend = DIVD_W'({hsel, 14'b0}) + DIVD_W'({hsel, 13'b0})
                         + DIVD_W'({hsel, 10'b0});
    assign dreq.divisor  = hrmax_prod[23:16];

    assign quo_sat = (|drsp.quotient[QUO_W-1:16]) ? 16'hFFFF : drsp.quotient[15:0];

    assign rnd  = mul_p + ROUND_HALF;
    assign inc  = rnd[MP_W-1:20];
    assign ksum = KSUM_W'(kcal_reg) + KSUM_W'(inc);
    assign ktop = ksum[KSUM_W-1:KCAL_BITS-1];

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_M0:
            begin
                mul_a = MA_W'(avg_reg);
                mul_b = male_reg ? M_CA : F_CA;
            end
            S_M1:
            begin
                mul_a = MA_W'(weight_reg);
                mul_b = male_reg ? M_CW16 : F_CW16;
            end
            S_M2:
            begin
                mul_a = MA_W'(age_reg);
                mul_b = male_reg ? M_CY16 : F_CY16;
            end
            S_M4:
            begin
                mul_a = acc_reg;
                mul_b = MB_W'(dur_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        age_next     = age_reg;
        male_next    = male_reg;
        weight_next  = weight_reg;
        peak_next    = peak_reg;
        resting_next = resting_reg;
        pct_next     = pct_reg;
        zone_next    = zone_reg;
        kcal_next    = kcal_reg;
        op_next      = op_reg;
        hr_next      = hr_reg;
        avg_next     = avg_reg;
        dur_next     = dur_reg;
        newpct_next  = newpct_reg;
        acc_next     = acc_reg;
        knew_next    = knew_reg;
        ovalid_next  = ovalid_reg;
        omax_next    = omax_reg;
        orest_next   = orest_reg;
        opct_next    = opct_reg;
        ozone_next   = ozone_reg;
        okcal_next   = okcal_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_AGE:    age_next    = cfg_data[6:0];
                CFG_MALE:   male_next   = cfg_data[0];
                CFG_WEIGHT: weight_next = cfg_data;
                default:    ;
            endcase
        end

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    hr_next    = heart_rate;
                    avg_next   = avg_heart_rate;
                    dur_next   = duration_min;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    newpct_next = quo_sat;
                    state_next  = (op_reg == OP_INTERVAL) ? S_M0 : S_COMMIT;
                end
            end
            S_M0:
            begin
                acc_next   = male_reg ? M_K16 : F_K16;
                state_next = S_M1;
            end
            S_M1:
            begin
                acc_next   = acc_reg + mul_p[MA_W-1:0];
                state_next = S_M2;
            end
            S_M2:
            begin
                acc_next   = acc_reg + mul_p[MA_W-1:0];
                state_next = S_M3;
            end
            S_M3:
            begin
                acc_next   = acc_reg + mul_p[MA_W-1:0];
                state_next = S_M4;
            end
            S_M4:
            begin
                state_next = S_M5;
            end
            S_M5:
            begin
                if ((&ktop) || !(|ktop))
                begin
                    knew_next = ksum[KCAL_BITS-1:0];
                end
                else if (ksum[KSUM_W-1])
                begin
                    knew_next = {1'b1, {(KCAL_BITS-1){1'b0}}};
                end
                else
                begin
                    knew_next = {1'b0, {(KCAL_BITS-1){1'b1}}};
                end
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    pct_next  = newpct_reg;
                    opct_next = newpct_reg;
                    omax_next = peak_reg;
                    orest_next = resting_reg;
                    ozone_next = zone_reg;
                    okcal_next = kcal_reg;
                    if (op_reg == OP_SAMPLE)
                    begin
                        if (hr_reg > peak_reg)
                        begin
                            peak_next = hr_reg;
                            omax_next = hr_reg;
                        end
                        if ((hr_reg != 8'd0) && ({2'b0, hr_reg} < resting_reg))
                        begin
                            resting_next = {2'b0, hr_reg};
                            orest_next   = {2'b0, hr_reg};
                        end
                        if (newpct_reg < PCT_60)
                        begin
                            zone_next = 3'd1;
                        end
                        else if (newpct_reg < PCT_70)
                        begin
                            zone_next = 3'd2;
                        end
                        else if (newpct_reg < PCT_80)
                        begin
                            zone_next = 3'd3;
                        end
                        else if (newpct_reg < PCT_90)
                        begin
                            zone_next = 3'd4;
                        end
                        else
                        begin
                            zone_next = 3'd5;
                        end
                        ozone_next = zone_next;
                    end
                    else if (newpct_reg > PCT_60)
                    begin
                        kcal_next  = knew_reg;
                        okcal_next = knew_reg;
                    end
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            age_reg     <= AGE_RST;
            male_reg    <= 1'b1;
            weight_reg  <= WEIGHT_RST;
            peak_reg    <= '0;
            resting_reg <= REST_RST;
            pct_reg     <= '0;
            zone_reg    <= ZONE_RST;
            kcal_reg    <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            age_reg     <= age_next;
            male_reg    <= male_next;
            weight_reg  <= weight_next;
            peak_reg    <= peak_next;
            resting_reg <= resting_next;
            pct_reg     <= pct_next;
            zone_reg    <= zone_next;
            kcal_reg    <= kcal_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        hr_reg     <= hr_next;
        avg_reg    <= avg_next;
        dur_reg    <= dur_next;
        newpct_reg <= newpct_next;
        acc_reg    <= acc_next;
        knew_reg   <= knew_next;
        omax_reg   <= omax_next;
        orest_reg  <= orest_next;
        opct_reg   <= opct_next;
        ozone_reg  <= ozone_next;
        okcal_reg  <= okcal_next;
    end

    assign kcal_wide = 64'(okcal_reg);

    assign out_valid      = ovalid_reg;
    assign max_rate       = omax_reg;
    assign rest_rate      = orest_reg;
    assign percent_of_max = opct_reg;
    assign zone           = ozone_reg;
    assign total_kcal     = kcal_wide[31:0];

endmodule

>>> rtl/hrft_checker.sv
module hrft_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  max_rate,
    input logic [9:0]  rest_rate,
    input logic [15:0] percent_of_max,
    input logic [2:0]  zone,
    input logic [31:0] total_kcal
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(max_rate) && $stable(rest_rate)
            && $stable(percent_of_max) && $stable(zone) && $stable(total_kcal))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while busy");

    a_zone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> zone >= 3'd1 && zone <= 3'd5)
        else $error("zone out of range");

    a_rest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rest_rate <= 10'd1000)
        else $error("resting rate out of range");

endmodule

bind heart_rate_fitness_tracker_unit hrft_checker u_hrft_checker (.*);

>>> tb/heart_rate_fitness_tracker_unit_tb.sv
`timescale 1ns / 100ps

module heart_rate_fitness_tracker_unit_tb;
    import hrft_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT_RESULT = 150;
    localparam int DRAIN_CYCLES   = 64;
    localparam int MAX_GAP        = 20;
    localparam int PHASE_ITEMS    = 130;
    localparam int SAT_ITEMS      = 780;
    localparam int DEFAULT_ROWS   = 18;

    typedef struct packed {
        logic [7:0]         max_rate;
        logic [9:0]         rest_rate;
        logic [15:0]        percent_of_max;
        logic [2:0]         zone;
        logic signed [31:0] total_kcal;
    } fitness_stats_t;

    typedef struct packed {
        logic           op;
        logic [7:0]     hr;
        logic [11:0]    avg;
        logic [15:0]    dur;
        logic           typed;
        fitness_stats_t want;
    } vector_t;

    localparam fitness_stats_t AFTER_RESET = {8'd0, REST_RST, 16'd0, ZONE_RST, 32'd0};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               op = OP_SAMPLE;
    logic [7:0]         heart_rate = '0;
    logic [11:0]        avg_heart_rate = '0;
    logic [15:0]        duration_min = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         max_rate;
    logic [9:0]         rest_rate;
    logic [15:0]        percent_of_max;
    logic [2:0]         zone;
    logic signed [31:0] total_kcal;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [7:0]         cfg_data = '0;

    heart_rate_fitness_tracker_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .heart_rate(heart_rate),
        .avg_heart_rate(avg_heart_rate),
        .duration_min(duration_min),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .max_rate(max_rate),
        .rest_rate(rest_rate),
        .percent_of_max(percent_of_max),
        .zone(zone),
        .total_kcal(total_kcal),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // tracker state as predicted
    logic [6:0]  p_age = AGE_RST;
    logic        p_male = 1'b1;
    logic [7:0]  p_weight = WEIGHT_RST;
    logic [7:0]  p_peak = '0;
    logic [9:0]  p_rest = REST_RST;
    logic [15:0] p_pct = '0;
    logic [2:0]  p_zone = ZONE_RST;
    longint      p_energy = 0;

    fitness_stats_t stats_due[$];
    vector_t        dir_tab[$];

    int errors = 0;
    int results_seen = 0;
    int hold_left = 0;
    bit pressure_done = 1'b0;
    int quiet = 0;
    int tx_idle_pct = 18;
    int rx_idle_pct = 80;

    function automatic logic [15:0] percent_of_peak(input int unsigned bpm);
        int unsigned hr_max;
        int unsigned pct;
        hr_max = (int'(HRMAX_X10) - 7 * int'(p_age)) / 10;
        pct = bpm * 25600 / hr_max;
        return (pct > 65535) ? 16'hFFFF : 16'(pct);
    endfunction

    function automatic logic [2:0] zone_of(input logic [15:0] pct);
        if (pct < PCT_60)
            return 3'd1;
        if (pct < PCT_70)
            return 3'd2;
        if (pct < PCT_80)
            return 3'd3;
        if (pct < PCT_90)
            return 3'd4;
        return 3'd5;
    endfunction

    function automatic fitness_stats_t update_fitness_stats(input logic o, input logic [7:0] h,
                                                            input logic [11:0] a,
                                                            input logic [15:0] d);
        longint         rate;
        longint         gain;
        longint         sum;
        longint         ceiling;
        fitness_stats_t s;
        ceiling = (longint'(1) <<< (KCAL_BITS - 1)) - 1;
        if (o == OP_SAMPLE)
        begin
            if (h > p_peak)
                p_peak = h;
            if (h != 0 && h < p_rest)
                p_rest = h;
            p_pct = percent_of_peak(h);
            p_zone = zone_of(p_pct);
        end
        else
        begin
            p_pct = percent_of_peak(a[11:4]);
            if (p_pct > PCT_60)
            begin
                if (p_male)
                    rate = 9882 * longint'(a)
                         + 16 * (3114 * longint'(p_weight) + 3159 * longint'(p_age) - 863009);
                else
                    rate = 7005 * longint'(a)
                         + 16 * (1159 * longint'(p_age) - 1978 * longint'(p_weight) - 319569);
                gain = (rate * longint'(d) + 524288) >>> 20;
                sum = p_energy + gain;
                if (sum > ceiling)
                    sum = ceiling;
                if (sum < -ceiling - 1)
                    sum = -ceiling - 1;
                p_energy = sum;
            end
        end
        s.max_rate = p_peak;
        s.rest_rate = p_rest;
        s.percent_of_max = p_pct;
        s.zone = p_zone;
        s.total_kcal = p_energy[31:0];
        return s;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic add_vector(input logic o, input logic [7:0] h, input logic [11:0] a,
                              input logic [15:0] d, input logic typed,
                              input fitness_stats_t want);
        vector_t v;
        v.op = o;
        v.hr = h;
        v.avg = a;
        v.dur = d;
        v.typed = typed;
        v.want = want;
        dir_tab.push_back(v);
    endtask

    task automatic send_item(input logic o, input logic [7:0] h, input logic [11:0] a,
                             input logic [15:0] d, input logic typed,
                             input fitness_stats_t want);
        int             gap;
        fitness_stats_t pred;
        op <= o;
        heart_rate <= h;
        avg_heart_rate <= a;
        duration_min <= d;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        pred = update_fitness_stats(o, h, a, d);
        stats_due.push_back(typed ? want : pred);
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_item();
        logic        o;
        logic [7:0]  h;
        logic [11:0] a;
        logic [15:0] d;
        o = 1'($urandom_range(1));
        case ($urandom_range(7))
            0: h = 8'd0;
            1: h = 8'hFF;
            default: h = 8'($urandom_range(255));
        endcase
        a = 12'($urandom_range(4095));
        d = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(4095));
        send_item(o, h, a, d, 1'b0, '0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_AGE:    p_age = val[6:0];
            CFG_MALE:   p_male = val[0];
            CFG_WEIGHT: p_weight = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (stats_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_profile(input logic [7:0] age_v, input logic [7:0] male_v,
                               input logic [7:0] weight_v);
        drain();
        write_reg(CFG_AGE, age_v);
        write_reg(CFG_MALE, male_v);
        write_reg(CFG_WEIGHT, weight_v);
        write_reg(CFG_SPARE, 8'($urandom_range(255)));
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : result_side
        fitness_stats_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (stats_due.size() == 0)
                begin
                    $display("%0t ns: unexpected item: expected none, actual %0d %0d %0d %0d %0d",
                             $time, max_rate, rest_rate, percent_of_max, zone, total_kcal);
                    errors++;
                end
                else
                begin
                    want = stats_due.pop_front();
                    check_field("max_rate", want.max_rate, max_rate);
                    check_field("rest_rate", want.rest_rate, rest_rate);
                    check_field("percent_of_max", want.percent_of_max, percent_of_max);
                    check_field("zone", want.zone, zone);
                    check_field("total_kcal", $signed(want.total_kcal), total_kcal);
                end
                results_seen++;
            end
            if (!pressure_done && results_seen == HOLD_AT_RESULT)
            begin
                hold_left = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("heart_rate_fitness_tracker_unit test failed");
            $finish;
        end
    end

    initial
    begin : main_seq
        vector_t v;

        // default profile: age 30, male, 70 kg, predicted max 188
        add_vector(OP_SAMPLE,   8'd0,   12'd0,    16'd0,      1'b1, AFTER_RESET);
        add_vector(OP_INTERVAL, 8'd0,   12'd0,    16'hFFFF,   1'b1, AFTER_RESET);
        add_vector(OP_SAMPLE,   8'd255, 12'hFFF,  16'hFFFF,   1'b0, '0);
        add_vector(OP_SAMPLE,   8'd1,   12'd0,    16'd0,      1'b0, '0);
        add_vector(OP_SAMPLE,   8'd0,   12'hFFF,  16'hFFFF,   1'b0, '0);
        add_vector(OP_SAMPLE,   8'd112, 12'd0,    16'd0,      1'b0, '0);
        add_vector(OP_SAMPLE,   8'd113, 12'd0,    16'd0,      1'b0, '0);
        add_vector(OP_SAMPLE,   8'd131, 12'd0,    16'd0,      1'b0, '0);
        add_vector(OP_SAMPLE,   8'd132, 12'd0,    16'd0,      1'b0, '0);
        add_vector(OP_SAMPLE,   8'd150, 12'd0,    16'd0,      1'b0, '0);
        add_vector(OP_SAMPLE,   8'd151, 12'd0,    16'd0,      1'b0, '0);
        add_vector(OP_SAMPLE,   8'd169, 12'd0,    16'd0,      1'b0, '0);
        add_vector(OP_SAMPLE,   8'd170, 12'd0,    16'd0,      1'b0, '0);
        add_vector(OP_INTERVAL, 8'hFF,  12'd1807, 16'h0100,   1'b0, '0);
        add_vector(OP_INTERVAL, 8'hFF,  12'd1808, 16'h0100,   1'b0, '0);
        add_vector(OP_INTERVAL, 8'd0,   12'hFFF,  16'hFFFF,   1'b0, '0);
        add_vector(OP_INTERVAL, 8'd0,   12'hFFF,  16'd0,      1'b0, '0);
        add_vector(OP_INTERVAL, 8'd0,   12'hFFF,  16'd1,      1'b0, '0);
        // oldest heavy female: negative energy rate at and just above the 60 percent bound
        add_vector(OP_INTERVAL, 8'd0,   12'd1167, 16'hFFFF,   1'b0, '0);
        add_vector(OP_INTERVAL, 8'd0,   12'd1168, 16'hFFFF,   1'b0, '0);
        add_vector(OP_INTERVAL, 8'd0,   12'd1169, 16'h00FF,   1'b0, '0);
        add_vector(OP_SAMPLE,   8'd72,  12'd0,    16'd0,      1'b0, '0);
        add_vector(OP_SAMPLE,   8'd73,  12'd0,    16'd0,      1'b0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            v = dir_tab[i];
            if (i == DEFAULT_ROWS)
                set_profile(8'hFF, 8'hFE, 8'hFF);
            send_item(v.op, v.hr, v.avg, v.dur, v.typed, v.want);
        end

        set_profile(8'd0, 8'd0, 8'd0);
        repeat (PHASE_ITEMS) send_random_item();

        set_profile(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
        tx_idle_pct = 80;
        rx_idle_pct = 18;
        repeat (PHASE_ITEMS) send_random_item();

        set_profile(8'd120, 8'd1, 8'd255);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (PHASE_ITEMS) send_random_item();

        // drive the total into its upper bound and keep it there
        set_profile(8'h7F, 8'h01, 8'hFF);
        repeat (SAT_ITEMS) send_item(OP_INTERVAL, 8'($urandom_range(255)), 12'hFFF, 16'hFFFF,
                                     1'b0, '0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("heart_rate_fitness_tracker_unit test passed");
        else
            $display("heart_rate_fitness_tracker_unit test failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/hrft_pkg.sv
rtl/hrft_div.sv
rtl/hrft_mul.sv
rtl/heart_rate_fitness_tracker_unit.sv
rtl/hrft_checker.sv
tb/heart_rate_fitness_tracker_unit_tb.sv
